/* design/aas_pkg.sv */
// aas_pkg: payload structs, architectural state struct, opcodes and codes
// for the accumulator add/and ALU step block
// no dependencies
`default_nettype none

package aas_pkg;

  typedef struct packed {
    logic        command;
    logic [7:0]  opcode;
    logic [7:0]  operand_byte;
    logic [7:0]  memory_byte;
    logic [2:0]  pair_index;
    logic [15:0] pair_value;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  cycles;
    logic [7:0]  accumulator;
    logic [7:0]  flag_byte;
    logic [15:0] hl_pair;
    logic [15:0] next_pc;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  flags;
    logic [15:0] bc;
    logic [15:0] de;
    logic [15:0] hl;
    logic [15:0] sp;
    logic [15:0] pc;
  } arch_state_t;

  localparam logic [15:0] SP_RESET = 16'hDFF0;

  // command codes
  localparam logic CMD_EXEC = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // register pair codes for the load command
  localparam logic [2:0] PAIR_AF = 3'd0;
  localparam logic [2:0] PAIR_BC = 3'd1;
  localparam logic [2:0] PAIR_DE = 3'd2;
  localparam logic [2:0] PAIR_HL = 3'd3;
  localparam logic [2:0] PAIR_SP = 3'd4;
  localparam logic [2:0] PAIR_PC = 3'd5;

  // 8-bit operand select codes (low three opcode bits)
  localparam logic [2:0] SRC_B   = 3'd0;
  localparam logic [2:0] SRC_C   = 3'd1;
  localparam logic [2:0] SRC_D   = 3'd2;
  localparam logic [2:0] SRC_E   = 3'd3;
  localparam logic [2:0] SRC_H   = 3'd4;
  localparam logic [2:0] SRC_L   = 3'd5;
  localparam logic [2:0] SRC_MEM = 3'd6;
  localparam logic [2:0] SRC_A   = 3'd7;

  // opcodes
  localparam logic [7:0] OP_ADD_FIRST = 8'h80;
  localparam logic [7:0] OP_ADC_LAST  = 8'h8F;
  localparam logic [7:0] OP_AND_FIRST = 8'hA0;
  localparam logic [7:0] OP_AND_LAST  = 8'hA7;
  localparam logic [7:0] OP_ADD_IMM   = 8'hC6;
  localparam logic [7:0] OP_ADC_IMM   = 8'hCE;
  localparam logic [7:0] OP_AND_IMM   = 8'hE6;
  localparam logic [7:0] OP_ADD_HL_BC = 8'h09;
  localparam logic [7:0] OP_ADD_HL_DE = 8'h19;
  localparam logic [7:0] OP_ADD_HL_HL = 8'h29;
  localparam logic [7:0] OP_ADD_HL_SP = 8'h39;

  // flag bit positions
  localparam int FLG_S  = 7;
  localparam int FLG_Z  = 6;
  localparam int FLG_H  = 4;
  localparam int FLG_PV = 2;
  localparam int FLG_C  = 0;
  // bits kept by the 16-bit add: S Z 5 3 PV
  localparam logic [7:0] FLG_KEEP16 = 8'hEC;

  localparam logic [3:0] CYC_NONE = 4'd0;
  localparam logic [3:0] CYC_REG  = 4'd4;
  localparam logic [3:0] CYC_MEM  = 4'd7;
  localparam logic [3:0] CYC_W16  = 4'd11;

  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_UNKNOWN = 1'b1;

endpackage

`default_nettype wire

/* design/accumulator_add_and_alu_step.sv */
// accumulator_add_and_alu_step: top level with input register, state
// registers and result register; depends on aas_pkg and aas_exec
//
// Usage:
// - in_valid/in_ready/in_data carry one item: execute an opcode or load a
//   register pair. out_valid/out_ready/out_data return exactly one result
//   per item, in order.
// - An accepted item sits in the input register, where the decoder, the
//   8-bit adder/and and the 16-bit adder work on it against the
//   architectural registers; when it advances, one edge writes the new
//   state and the result register together.
// - Throughput is one item per cycle while out_ready is high: each item
//   sees the state left by the one before it, since state is written in
//   the same edge it leaves the execute stage.
// - When out_ready is low the result register holds, the input register
//   holds its item and in_ready stays high only while that register is
//   empty, so at most two items are in flight.
// - Synchronous active-low reset empties both registers, clears A, F, BC,
//   DE, HL and PC and sets SP to 0xDFF0.
`default_nettype none

module accumulator_add_and_alu_step (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire aas_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output aas_pkg::out_item_t       out_data
);
  import aas_pkg::*;

  logic        in_valid_r;
  in_item_t    in_item_r;
  logic        out_valid_r;
  out_item_t   out_data_r;
  arch_state_t state_r;
  arch_state_t state_nxt;
  out_item_t   res_nxt;
  logic        advance;

  aas_exec u_exec (
    .item (in_item_r),
    .cur  (state_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  assign advance  = in_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~in_valid_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.acc   <= 8'h00;
      state_r.flags <= 8'h00;
      state_r.bc    <= 16'h0000;
      state_r.de    <= 16'h0000;
      state_r.hl    <= 16'h0000;
      state_r.sp    <= SP_RESET;
      state_r.pc    <= 16'h0000;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a stalled execute stage keeps its item
  a_hold_in : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r)
    else $error("input register lost an item under stall");

  // an executed opcode moves pc by one or two
  a_pc_step : assert property (@(posedge clk) disable iff (!rst_n)
    advance && (in_item_r.command == CMD_EXEC) |=>
      (state_r.pc == $past(state_r.pc) + 16'd1) ||
      (state_r.pc == $past(state_r.pc) + 16'd2))
    else $error("pc did not advance correctly");

  // unknown opcodes report no cycles
  a_unknown_cycles : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status == STAT_UNKNOWN) |-> out_data_r.cycles == CYC_NONE)
    else $error("unknown opcode with nonzero cycles");

  // a load never leaves the result as unknown
  a_load_status : assert property (@(posedge clk) disable iff (!rst_n)
    advance && (in_item_r.command == CMD_LOAD) |=> out_data_r.status == STAT_OK)
    else $error("load reported as unknown opcode");

  // result register reflects state written in the same edge
  a_res_state : assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_data_r.next_pc == state_r.pc) && (out_data_r.hl_pair == state_r.hl))
    else $error("result and state out of step");

endmodule

`default_nettype wire

/* design/aas_exec.sv */
// aas_exec: combinational execute of one item against the current state
// depends on aas_pkg
`default_nettype none

module aas_exec (
  input  wire aas_pkg::in_item_t    item,
  input  wire aas_pkg::arch_state_t cur,
  output aas_pkg::arch_state_t      nxt,
  output aas_pkg::out_item_t        res
);
  import aas_pkg::*;

  logic [7:0]  src8;
  logic [7:0]  opnd8;
  logic        cin;
  logic        do_add8;
  logic        do_and8;
  logic        do_add16;
  logic [15:0] opnd16;
  logic [8:0]  sum8;
  logic [4:0]  half8;
  logic [7:0]  r_add;
  logic [7:0]  f_add;
  logic [7:0]  r_and;
  logic [7:0]  f_and;
  logic [16:0] sum16;
  logic [12:0] half16;
  logic [7:0]  f_add16;

  always_comb begin
    case (item.opcode[2:0])
      SRC_B:   src8 = cur.bc[15:8];
      SRC_C:   src8 = cur.bc[7:0];
      SRC_D:   src8 = cur.de[15:8];
      SRC_E:   src8 = cur.de[7:0];
      SRC_H:   src8 = cur.hl[15:8];
      SRC_L:   src8 = cur.hl[7:0];
      SRC_MEM: src8 = item.memory_byte;
      default: src8 = cur.acc;
    endcase
  end

  // 8-bit adder and its flags
  assign sum8  = {1'b0, cur.acc} + {1'b0, opnd8} + {8'd0, cin};
  assign half8 = {1'b0, cur.acc[3:0]} + {1'b0, opnd8[3:0]} + {4'd0, cin};
  assign r_add = sum8[7:0];
  always_comb begin
    f_add         = 8'h00;
    f_add[FLG_S]  = r_add[7];
    f_add[FLG_Z]  = (r_add == 8'h00);
    f_add[FLG_H]  = half8[4];
    f_add[FLG_PV] = ~(cur.acc[7] ^ opnd8[7]) & (cur.acc[7] ^ r_add[7]);
    f_add[FLG_C]  = sum8[8];
  end

  // and with even parity
  assign r_and = cur.acc & opnd8;
  always_comb begin
    f_and         = 8'h00;
    f_and[FLG_S]  = r_and[7];
    f_and[FLG_Z]  = (r_and == 8'h00);
    f_and[FLG_H]  = 1'b1;
    f_and[FLG_PV] = ~(^r_and);
  end

  // 16-bit add into HL, S Z PV and the unused bits stay
  assign sum16  = {1'b0, cur.hl} + {1'b0, opnd16};
  assign half16 = {1'b0, cur.hl[11:0]} + {1'b0, opnd16[11:0]};
  always_comb begin
    f_add16        = cur.flags & FLG_KEEP16;
    f_add16[FLG_H] = half16[12];
    f_add16[FLG_C] = sum16[16];
  end

  always_comb begin
    opnd8      = src8;
    cin        = 1'b0;
    opnd16     = cur.bc;
    do_add8    = 1'b0;
    do_and8    = 1'b0;
    do_add16   = 1'b0;
    nxt        = cur;
    res.status = STAT_OK;
    res.cycles = CYC_NONE;

    if (item.command == CMD_LOAD) begin
      unique case (item.pair_index)
        PAIR_AF: begin
          nxt.acc   = item.pair_value[15:8];
          nxt.flags = item.pair_value[7:0];
        end
        PAIR_BC: nxt.bc = item.pair_value;
        PAIR_DE: nxt.de = item.pair_value;
        PAIR_HL: nxt.hl = item.pair_value;
        PAIR_SP: nxt.sp = item.pair_value;
        PAIR_PC: nxt.pc = item.pair_value;
        default: ;
      endcase
    end else begin
      nxt.pc = cur.pc + 16'd1;
      unique case (item.opcode) inside
        [OP_ADD_FIRST:OP_ADC_LAST]: begin
          do_add8    = 1'b1;
          cin        = item.opcode[3] & cur.flags[FLG_C];
          res.cycles = (item.opcode[2:0] == SRC_MEM) ? CYC_MEM : CYC_REG;
        end
        [OP_AND_FIRST:OP_AND_LAST]: begin
          do_and8    = 1'b1;
          res.cycles = (item.opcode[2:0] == SRC_MEM) ? CYC_MEM : CYC_REG;
        end
        OP_ADD_IMM, OP_ADC_IMM: begin
          do_add8    = 1'b1;
          opnd8      = item.operand_byte;
          cin        = (item.opcode == OP_ADC_IMM) & cur.flags[FLG_C];
          res.cycles = CYC_MEM;
          nxt.pc     = cur.pc + 16'd2;
        end
        OP_AND_IMM: begin
          do_and8    = 1'b1;
          opnd8      = item.operand_byte;
          res.cycles = CYC_MEM;
          nxt.pc     = cur.pc + 16'd2;
        end
        OP_ADD_HL_BC: begin
          do_add16 = 1'b1; opnd16 = cur.bc; res.cycles = CYC_W16;
        end
        OP_ADD_HL_DE: begin
          do_add16 = 1'b1; opnd16 = cur.de; res.cycles = CYC_W16;
        end
        OP_ADD_HL_HL: begin
          do_add16 = 1'b1; opnd16 = cur.hl; res.cycles = CYC_W16;
        end
        OP_ADD_HL_SP: begin
          do_add16 = 1'b1; opnd16 = cur.sp; res.cycles = CYC_W16;
        end
        default: res.status = STAT_UNKNOWN;
      endcase
      if (do_add8) begin
        nxt.acc   = r_add;
        nxt.flags = f_add;
      end
      if (do_and8) begin
        nxt.acc   = r_and;
        nxt.flags = f_and;
      end
      if (do_add16) begin
        nxt.hl    = sum16[15:0];
        nxt.flags = f_add16;
      end
    end

    res.accumulator = nxt.acc;
    res.flag_byte   = nxt.flags;
    res.hl_pair     = nxt.hl;
    res.next_pc     = nxt.pc;
  end

endmodule

`default_nettype wire

/* tb/accumulator_add_and_alu_step_test.sv */
// accumulator_add_and_alu_step_test: self-checking bench for the accumulator
// add/and ALU step, with a state-tracking scoreboard and random handshake idling
// depends on aas_pkg and accumulator_add_and_alu_step
`timescale 1ns / 100ps

module accumulator_add_and_alu_step_test;
  import aas_pkg::*;

  // mirrors the architectural registers and predicts each result
  class alu_scoreboard;
    arch_state_t regs;
    out_item_t   pending_results[$];
    int unsigned errors;

    function new();
      regs = '0;
      regs.sp = SP_RESET;
      errors = 0;
    endfunction

    function logic [7:0] operand8(logic [2:0] sel, logic [7:0] mem);
      case (sel)
        SRC_B: return regs.bc[15:8];
        SRC_C: return regs.bc[7:0];
        SRC_D: return regs.de[15:8];
        SRC_E: return regs.de[7:0];
        SRC_H: return regs.hl[15:8];
        SRC_L: return regs.hl[7:0];
        SRC_MEM: return mem;
        default: return regs.acc;
      endcase
    endfunction

    function void add8(logic [7:0] v, logic cin);
      logic [8:0] sum;
      logic [4:0] half;
      logic [7:0] r;
      logic [7:0] f;
      sum = {1'b0, regs.acc} + {1'b0, v} + {8'd0, cin};
      half = {1'b0, regs.acc[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
      r = sum[7:0];
      f = '0;
      f[FLG_S] = r[7];
      f[FLG_Z] = (r == 8'd0);
      f[FLG_H] = half[4];
      f[FLG_PV] = (regs.acc[7] == v[7]) && (r[7] != regs.acc[7]);
      f[FLG_C] = sum[8];
      regs.acc = r;
      regs.flags = f;
    endfunction

    function void and8(logic [7:0] v);
      logic [7:0] r;
      logic [7:0] f;
      r = regs.acc & v;
      f = '0;
      f[FLG_S] = r[7];
      f[FLG_Z] = (r == 8'd0);
      f[FLG_H] = 1'b1;
      f[FLG_PV] = ~^r;
      regs.acc = r;
      regs.flags = f;
    endfunction

    function void add16(logic [15:0] v);
      logic [16:0] sum;
      logic [12:0] half;
      logic [7:0] f;
      sum = {1'b0, regs.hl} + {1'b0, v};
      half = {1'b0, regs.hl[11:0]} + {1'b0, v[11:0]};
      f = regs.flags & FLG_KEEP16;
      f[FLG_H] = half[12];
      f[FLG_C] = sum[16];
      regs.hl = sum[15:0];
      regs.flags = f;
    endfunction

    function out_item_t step_alu(in_item_t it);
      out_item_t res;
      logic [15:0] pc_step;
      logic [2:0] src;
      res = '0;
      res.status = STAT_OK;
      res.cycles = CYC_NONE;
      src = it.opcode[2:0];
      if (it.command == CMD_LOAD) begin
        case (it.pair_index)
          PAIR_AF: begin
            regs.acc = it.pair_value[15:8];
            regs.flags = it.pair_value[7:0];
          end
          PAIR_BC: regs.bc = it.pair_value;
          PAIR_DE: regs.de = it.pair_value;
          PAIR_HL: regs.hl = it.pair_value;
          PAIR_SP: regs.sp = it.pair_value;
          PAIR_PC: regs.pc = it.pair_value;
          default: ;
        endcase
      end else begin
        pc_step = 16'd1;
        if (it.opcode >= OP_ADD_FIRST && it.opcode <= OP_ADC_LAST) begin
          // upper half of the group is the carry-in form
          add8(operand8(src, it.memory_byte), it.opcode[3] & regs.flags[FLG_C]);
          res.cycles = (src == SRC_MEM) ? CYC_MEM : CYC_REG;
        end else if (it.opcode >= OP_AND_FIRST && it.opcode <= OP_AND_LAST) begin
          and8(operand8(src, it.memory_byte));
          res.cycles = (src == SRC_MEM) ? CYC_MEM : CYC_REG;
        end else if (it.opcode == OP_ADD_IMM) begin
          add8(it.operand_byte, 1'b0);
          res.cycles = CYC_MEM;
          pc_step = 16'd2;
        end else if (it.opcode == OP_ADC_IMM) begin
          add8(it.operand_byte, regs.flags[FLG_C]);
          res.cycles = CYC_MEM;
          pc_step = 16'd2;
        end else if (it.opcode == OP_AND_IMM) begin
          and8(it.operand_byte);
          res.cycles = CYC_MEM;
          pc_step = 16'd2;
        end else if (it.opcode == OP_ADD_HL_BC) begin
          add16(regs.bc);
          res.cycles = CYC_W16;
        end else if (it.opcode == OP_ADD_HL_DE) begin
          add16(regs.de);
          res.cycles = CYC_W16;
        end else if (it.opcode == OP_ADD_HL_HL) begin
          add16(regs.hl);
          res.cycles = CYC_W16;
        end else if (it.opcode == OP_ADD_HL_SP) begin
          add16(regs.sp);
          res.cycles = CYC_W16;
        end else begin
          res.status = STAT_UNKNOWN;
        end
        regs.pc = regs.pc + pc_step;
      end
      res.accumulator = regs.acc;
      res.flag_byte = regs.flags;
      res.hl_pair = regs.hl;
      res.next_pc = regs.pc;
      return res;
    endfunction

    function void note_input(in_item_t it);
      pending_results.push_back(step_alu(it));
    endfunction

    function void check_field(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t ns: result with nothing expected, actual %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      check_field("status", 16'(want.status), 16'(got.status));
      check_field("cycles", 16'(want.cycles), 16'(got.cycles));
      check_field("accumulator", 16'(want.accumulator), 16'(got.accumulator));
      check_field("flag_byte", 16'(want.flag_byte), 16'(got.flag_byte));
      check_field("hl_pair", want.hl_pair, got.hl_pair);
      check_field("next_pc", want.next_pc, got.next_pc);
    endfunction
  endclass

  localparam int RANDOM_ITEMS = 1230;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  in_item_t  in_data = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;

  logic tx_calm = 1'b0;
  logic rx_calm = 1'b0;
  logic [7:0] wide_ops [4] = '{OP_ADD_HL_BC, OP_ADD_HL_DE, OP_ADD_HL_HL, OP_ADD_HL_SP};

  alu_scoreboard sb;

  accumulator_add_and_alu_step dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // in calm spells every draw is back-to-back; otherwise half of the draws are, the rest wait a random gap
  function automatic int draw_wait(logic calm);
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 18);
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 11))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic in_item_t fill_item();
    in_item_t it;
    it.command = CMD_EXEC;
    it.opcode = 8'($urandom);
    it.operand_byte = rand_byte();
    it.memory_byte = rand_byte();
    it.pair_index = 3'($urandom_range(0, 7));
    it.pair_value = {rand_byte(), rand_byte()};
    return it;
  endfunction

  function automatic in_item_t exec_item(logic [7:0] op, logic [7:0] imm, logic [7:0] mem);
    in_item_t it;
    it = fill_item();
    it.opcode = op;
    it.operand_byte = imm;
    it.memory_byte = mem;
    return it;
  endfunction

  function automatic in_item_t load_item(logic [2:0] idx, logic [15:0] value);
    in_item_t it;
    it = fill_item();
    it.command = CMD_LOAD;
    it.pair_index = idx;
    it.pair_value = value;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int unsigned pick;
    it = fill_item();
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      it.command = CMD_LOAD;
    end else if (pick >= 20) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: it.opcode = OP_ADD_FIRST + 8'($urandom_range(0, 15));
        4, 5: it.opcode = OP_AND_FIRST + 8'($urandom_range(0, 7));
        6: it.opcode = OP_ADD_IMM;
        7: it.opcode = OP_ADC_IMM;
        8: it.opcode = OP_AND_IMM;
        default: it.opcode = wide_ops[2'($urandom_range(0, 3))];
      endcase
    end
    return it;
  endfunction

  // valid stays high across back-to-back transfers, lowered only for a gap
  task automatic send_item(input in_item_t it);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    gap = draw_wait(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
  endtask

  // transfers are sampled at the edge, before any update from that edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  initial begin : result_sink
    int stall;
    forever begin
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      stall = draw_wait(rx_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: flag corners, every group, loads, unknown opcodes, pc wrap
    send_item(load_item(PAIR_BC, 16'h7F80));
    send_item(load_item(PAIR_DE, 16'hFF01));
    send_item(load_item(PAIR_HL, 16'h0FFF));
    send_item(load_item(PAIR_AF, 16'h0100));
    send_item(exec_item(OP_ADD_FIRST + SRC_B, 8'h00, 8'h00));
    send_item(exec_item(OP_ADD_FIRST + SRC_C, 8'h00, 8'h00));
    send_item(exec_item(OP_ADD_FIRST + 8'h08 + SRC_D, 8'h00, 8'h00));
    send_item(exec_item(OP_ADD_FIRST + SRC_MEM, 8'h00, 8'h0F));
    send_item(exec_item(OP_ADD_FIRST + 8'h08 + SRC_MEM, 8'h00, 8'hFF));
    send_item(exec_item(OP_AND_IMM, 8'h00, 8'hFF));
    send_item(exec_item(OP_ADD_IMM, 8'hFF, 8'h00));
    send_item(exec_item(OP_ADC_IMM, 8'h01, 8'h00));
    send_item(exec_item(OP_AND_FIRST + SRC_MEM, 8'h00, 8'hFF));
    send_item(exec_item(OP_AND_FIRST + SRC_A, 8'h00, 8'h00));
    send_item(load_item(PAIR_AF, 16'h00FF));
    send_item(exec_item(OP_ADD_HL_BC, 8'h00, 8'h00));
    send_item(exec_item(OP_ADD_HL_DE, 8'h00, 8'h00));
    send_item(exec_item(OP_ADD_HL_HL, 8'h00, 8'h00));
    send_item(exec_item(OP_ADD_HL_SP, 8'h00, 8'h00));
    send_item(exec_item(OP_ADD_FIRST + SRC_L, 8'h00, 8'h00));
    send_item(load_item(PAIR_SP, 16'hFFFF));
    send_item(exec_item(8'h00, 8'hFF, 8'hFF));
    send_item(exec_item(8'hFF, 8'h00, 8'h00));
    send_item(load_item(3'd6, 16'hFFFF));
    send_item(load_item(3'd7, 16'hFFFF));
    send_item(load_item(PAIR_PC, 16'hFFFF));
    send_item(exec_item(OP_ADD_IMM, 8'h01, 8'h00));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain_results();
      send_item(rand_item());
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
